### hdl/tmh_pkg.sv
// Package for the timer min-heap: field widths, action and status codes,
// controller states, datapath operations and the status bundle.
// No dependencies; every other file in the block refers to it.
`default_nettype none

package tmh_pkg;

  // Fixed widths of the channel fields.
  localparam int ACTION_W = 3;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

  // Action codes carried by an input transfer.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_MODIFY = 3'd1,
    ACT_TICK   = 3'd2,
    ACT_FIRE   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RD,
    S_SLOT_RD,
    S_DECIDE,
    S_CLEAR,
    S_LAST_RD,
    S_RM_CHK,
    S_DN_RD,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_PLACE,
    S_TK_RD,
    S_TK_CMP,
    S_FINISH
  } ctl_state_t;

  // Operations that the controller asks of the datapath, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_MAP_RD,
    OP_SLOT_RD,
    OP_SET_UNKNOWN,
    OP_SET_FULL,
    OP_START_KNOWN,
    OP_START_NEW,
    OP_START_FIRE,
    OP_LAST_RD,
    OP_TAKE_LAST,
    OP_CHILD_RD,
    OP_MOVE_DOWN,
    OP_PARENT_RD,
    OP_MOVE_UP,
    OP_PLACE,
    OP_ROOT_RD,
    OP_TICK_POP,
    OP_TICK_END,
    OP_EMIT
  } dp_op_t;

  // Conditions that the datapath reports back to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                id_ok;
    logic                known;
    logic                full;
    logic                cnt_zero;
    logic                has_child;
    logic                dn_stop;
    logic                moved;
    logic                hole_root;
    logic                up_stop;
    logic                rm_move;
    logic                due;
    logic                pend;
    logic                out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/tmh_in_if.sv
// Input channel of the timer min-heap: valid/ready handshake and one action.
// Depends on tmh_pkg for the field widths.
`default_nettype none

interface tmh_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmh_pkg::ACTION_W-1:0]  action;
  logic [tmh_pkg::ID_W-1:0]      timer_id;
  logic [tmh_pkg::TIME_W-1:0]    expire_time;
  logic [tmh_pkg::TIME_W-1:0]    now_time;

  modport source (output valid, action, timer_id, expire_time, now_time, input ready);
  modport sink   (input valid, action, timer_id, expire_time, now_time, output ready);
endinterface

`default_nettype wire

### hdl/tmh_out_if.sv
// Result channel of the timer min-heap: valid/ready handshake and one result.
// Depends on tmh_pkg for the field widths.
`default_nettype none

interface tmh_out_if;
  logic                          valid;
  logic                          ready;
  logic                          fired;
  logic [tmh_pkg::ID_W-1:0]      fired_id;
  logic                          last;
  logic [tmh_pkg::STATUS_W-1:0]  status;

  modport source (output valid, fired, fired_id, last, status, input ready);
  modport sink   (input valid, fired, fired_id, last, status, output ready);
endinterface

`default_nettype wire

### hdl/tmh_ctrl.sv
// Controller of the timer min-heap: sequences lookup, sift, removal, tick and clear.
// Depends on tmh_pkg for states, operations and the status bundle.
`default_nettype none

module tmh_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [tmh_pkg::ACTION_W-1:0] in_action,
  output logic                              in_ready,
  input  wire tmh_pkg::dp_status_t          status,
  output tmh_pkg::dp_op_t                   op
);

  tmh_pkg::ctl_state_t state_r;
  tmh_pkg::ctl_state_t state_nxt;
  tmh_pkg::action_t    act;
  tmh_pkg::action_t    in_act;

  assign act    = tmh_pkg::action_t'(status.act);
  assign in_act = tmh_pkg::action_t'(in_action);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmh_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_act) inside
            tmh_pkg::ACT_ADD, tmh_pkg::ACT_MODIFY, tmh_pkg::ACT_FIRE:
              state_nxt = tmh_pkg::S_MAP_RD;
            tmh_pkg::ACT_TICK:  state_nxt = tmh_pkg::S_TK_RD;
            tmh_pkg::ACT_CLEAR: state_nxt = tmh_pkg::S_CLEAR;
            default:            state_nxt = tmh_pkg::S_FINISH;
          endcase
        end
      end
      tmh_pkg::S_MAP_RD:  state_nxt = tmh_pkg::S_SLOT_RD;
      tmh_pkg::S_SLOT_RD: state_nxt = tmh_pkg::S_DECIDE;
      tmh_pkg::S_DECIDE: begin
        state_nxt = tmh_pkg::S_FINISH;
        unique case (act)
          tmh_pkg::ACT_ADD: begin
            if (!status.id_ok) begin
              state_nxt = tmh_pkg::S_FINISH;
            end else if (status.known) begin
              state_nxt = tmh_pkg::S_DN_RD;
            end else if (status.full) begin
              state_nxt = tmh_pkg::S_FINISH;
            end else begin
              state_nxt = tmh_pkg::S_DN_RD;
            end
          end
          tmh_pkg::ACT_MODIFY: begin
            if (status.known) state_nxt = tmh_pkg::S_DN_RD;
          end
          tmh_pkg::ACT_FIRE: begin
            if (status.known) state_nxt = tmh_pkg::S_LAST_RD;
          end
          default: state_nxt = tmh_pkg::S_FINISH;
        endcase
      end
      tmh_pkg::S_CLEAR:   state_nxt = tmh_pkg::S_FINISH;
      tmh_pkg::S_LAST_RD: state_nxt = tmh_pkg::S_RM_CHK;
      tmh_pkg::S_RM_CHK: begin
        if (status.rm_move) begin
          state_nxt = tmh_pkg::S_DN_RD;
        end else if (act == tmh_pkg::ACT_TICK) begin
          state_nxt = tmh_pkg::S_TK_RD;
        end else begin
          state_nxt = tmh_pkg::S_FINISH;
        end
      end
      tmh_pkg::S_DN_RD: begin
        if (status.has_child) begin
          state_nxt = tmh_pkg::S_DN_CMP;
        end else begin
          state_nxt = status.moved ? tmh_pkg::S_PLACE : tmh_pkg::S_UP_RD;
        end
      end
      tmh_pkg::S_DN_CMP: begin
        if (status.dn_stop) begin
          state_nxt = status.moved ? tmh_pkg::S_PLACE : tmh_pkg::S_UP_RD;
        end else begin
          state_nxt = tmh_pkg::S_DN_RD;
        end
      end
      tmh_pkg::S_UP_RD: begin
        state_nxt = status.hole_root ? tmh_pkg::S_PLACE : tmh_pkg::S_UP_CMP;
      end
      tmh_pkg::S_UP_CMP: begin
        state_nxt = status.up_stop ? tmh_pkg::S_PLACE : tmh_pkg::S_UP_RD;
      end
      tmh_pkg::S_PLACE: begin
        state_nxt = (act == tmh_pkg::ACT_TICK) ? tmh_pkg::S_TK_RD : tmh_pkg::S_FINISH;
      end
      tmh_pkg::S_TK_RD: begin
        state_nxt = status.cnt_zero ? tmh_pkg::S_FINISH : tmh_pkg::S_TK_CMP;
      end
      tmh_pkg::S_TK_CMP: begin
        if (!status.due) begin
          state_nxt = tmh_pkg::S_FINISH;
        end else if (!status.pend || status.out_free) begin
          state_nxt = tmh_pkg::S_LAST_RD;
        end
      end
      tmh_pkg::S_FINISH: begin
        if (status.out_free) state_nxt = tmh_pkg::S_IDLE;
      end
      default: state_nxt = tmh_pkg::S_IDLE;
    endcase
  end

  // Output logic: handshake and datapath operation.
  always_comb begin
    in_ready = 1'b0;
    op       = tmh_pkg::OP_NONE;
    unique case (state_r)
      tmh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = tmh_pkg::OP_LOAD;
      end
      tmh_pkg::S_MAP_RD:  op = tmh_pkg::OP_MAP_RD;
      tmh_pkg::S_SLOT_RD: op = tmh_pkg::OP_SLOT_RD;
      tmh_pkg::S_DECIDE: begin
        op = tmh_pkg::OP_SET_UNKNOWN;
        unique case (act)
          tmh_pkg::ACT_ADD: begin
            if (!status.id_ok) begin
              op = tmh_pkg::OP_SET_UNKNOWN;
            end else if (status.known) begin
              op = tmh_pkg::OP_START_KNOWN;
            end else if (status.full) begin
              op = tmh_pkg::OP_SET_FULL;
            end else begin
              op = tmh_pkg::OP_START_NEW;
            end
          end
          tmh_pkg::ACT_MODIFY: begin
            if (status.known) op = tmh_pkg::OP_START_KNOWN;
          end
          tmh_pkg::ACT_FIRE: begin
            if (status.known) op = tmh_pkg::OP_START_FIRE;
          end
          default: op = tmh_pkg::OP_NONE;
        endcase
      end
      tmh_pkg::S_CLEAR:   op = tmh_pkg::OP_CLEAR;
      tmh_pkg::S_LAST_RD: op = tmh_pkg::OP_LAST_RD;
      tmh_pkg::S_RM_CHK: begin
        if (status.rm_move) op = tmh_pkg::OP_TAKE_LAST;
      end
      tmh_pkg::S_DN_RD: begin
        if (status.has_child) op = tmh_pkg::OP_CHILD_RD;
      end
      tmh_pkg::S_DN_CMP: begin
        if (!status.dn_stop) op = tmh_pkg::OP_MOVE_DOWN;
      end
      tmh_pkg::S_UP_RD: begin
        if (!status.hole_root) op = tmh_pkg::OP_PARENT_RD;
      end
      tmh_pkg::S_UP_CMP: begin
        if (!status.up_stop) op = tmh_pkg::OP_MOVE_UP;
      end
      tmh_pkg::S_PLACE: op = tmh_pkg::OP_PLACE;
      tmh_pkg::S_TK_RD: begin
        op = status.cnt_zero ? tmh_pkg::OP_TICK_END : tmh_pkg::OP_ROOT_RD;
      end
      tmh_pkg::S_TK_CMP: begin
        if (!status.due) begin
          op = tmh_pkg::OP_TICK_END;
        end else if (!status.pend || status.out_free) begin
          op = tmh_pkg::OP_TICK_POP;
        end
      end
      tmh_pkg::S_FINISH: begin
        if (status.out_free) op = tmh_pkg::OP_EMIT;
      end
      default: op = tmh_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/tmh_dpath.sv
// Datapath of the timer min-heap: heap and id-to-slot memories, the moving
// entry, the heap count and the result register. Depends on tmh_pkg.
`default_nettype none

module tmh_dpath #(
  parameter int HEAP_DEPTH = 64,
  parameter int ID_COUNT   = 256,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tmh_pkg::dp_op_t              op,
  output tmh_pkg::dp_status_t               status,
  input  wire logic [tmh_pkg::ACTION_W-1:0] in_action,
  input  wire logic [tmh_pkg::ID_W-1:0]     in_timer_id,
  input  wire logic [tmh_pkg::TIME_W-1:0]   in_expire_time,
  input  wire logic [tmh_pkg::TIME_W-1:0]   in_now_time,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic                              out_fired,
  output logic [tmh_pkg::ID_W-1:0]          out_fired_id,
  output logic                              out_last,
  output logic [tmh_pkg::STATUS_W-1:0]      out_status
);

  localparam int ID_W      = tmh_pkg::ID_W;
  localparam int KEY_W     = (TIME_BITS < tmh_pkg::TIME_W) ? TIME_BITS : tmh_pkg::TIME_W;
  localparam int IDX_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W     = $clog2(HEAP_DEPTH + 1);
  localparam int J_W       = CNT_W + 1;
  localparam int MAP_DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int ENT_W     = ID_W + KEY_W;

  // Heap entries hold {owner id, expiry}; the map holds each id's slot.
  logic [ENT_W-1:0] heap_mem [HEAP_DEPTH];
  logic [IDX_W-1:0] map_mem  [MAP_DEPTH];

  logic [tmh_pkg::ACTION_W-1:0] act_r;
  logic [ID_W-1:0]              id_r;
  logic [KEY_W-1:0]             exp_r;
  logic [KEY_W-1:0]             now_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [IDX_W-1:0]             slot_rd_r;
  logic [ENT_W-1:0]             rd_a_r;
  logic [ENT_W-1:0]             rd_b_r;
  logic [ENT_W-1:0]             ent_r;
  logic [IDX_W-1:0]             hole_r;
  logic [CNT_W-1:0]             lim_r;
  logic                         moved_r;
  logic                         pend_r;
  logic [ID_W-1:0]              pend_id_r;
  logic                         res_fired_r;
  logic [ID_W-1:0]              res_id_r;
  logic [tmh_pkg::STATUS_W-1:0] res_status_r;
  logic                         out_valid_r;
  logic                         out_fired_r;
  logic [ID_W-1:0]              out_id_r;
  logic                         out_last_r;
  logic [tmh_pkg::STATUS_W-1:0] out_status_r;

  logic [J_W-1:0]   child_l;
  logic [J_W-1:0]   child_r;
  logic [IDX_W-1:0] parent;
  logic             right_ok;
  logic             pick_right;
  logic [ENT_W-1:0] pick_ent;
  logic [IDX_W-1:0] pick_idx;
  logic             out_free;

  logic             rd_a_en;
  logic             rd_b_en;
  logic [IDX_W-1:0] rd_a_addr;
  logic [IDX_W-1:0] rd_b_addr;
  logic             heap_we;
  logic [IDX_W-1:0] heap_wa;
  logic [ENT_W-1:0] heap_wd;
  logic [ID_W-1:0]  wr_owner;

  // Neighbours of the hole and the smaller child.
  assign child_l    = J_W'({hole_r, 1'b1});
  assign child_r    = child_l + J_W'(1);
  assign parent     = IDX_W'((hole_r - IDX_W'(1)) >> 1);
  assign right_ok   = child_r < J_W'(lim_r);
  assign pick_right = right_ok && (rd_b_r[KEY_W-1:0] < rd_a_r[KEY_W-1:0]);
  assign pick_ent   = pick_right ? rd_b_r : rd_a_r;
  assign pick_idx   = pick_right ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
  assign out_free   = !out_valid_r || out_ready;

  // Read addresses for the two heap ports.
  always_comb begin
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_addr = '0;
    rd_b_addr = '0;
    case (op)
      tmh_pkg::OP_SLOT_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = slot_rd_r;
      end
      tmh_pkg::OP_LAST_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = IDX_W'(cnt_r - CNT_W'(1));
      end
      tmh_pkg::OP_CHILD_RD: begin
        rd_a_en   = 1'b1;
        rd_b_en   = 1'b1;
        rd_a_addr = child_l[IDX_W-1:0];
        rd_b_addr = child_r[IDX_W-1:0];
      end
      tmh_pkg::OP_PARENT_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = parent;
      end
      tmh_pkg::OP_ROOT_RD: begin
        rd_a_en   = 1'b1;
        rd_a_addr = '0;
      end
      default: ;
    endcase
  end

  // Write into the hole: a moved neighbour or the final placement.
  always_comb begin
    heap_we = 1'b0;
    heap_wa = hole_r;
    heap_wd = ent_r;
    case (op)
      tmh_pkg::OP_MOVE_DOWN: begin
        heap_we = 1'b1;
        heap_wd = pick_ent;
      end
      tmh_pkg::OP_MOVE_UP: begin
        heap_we = 1'b1;
        heap_wd = rd_a_r;
      end
      tmh_pkg::OP_PLACE: begin
        heap_we = 1'b1;
        heap_wd = ent_r;
      end
      default: ;
    endcase
  end

  // Owner of the entry being written, which selects the map entry to update.
  assign wr_owner = heap_wd[ENT_W-1 -: ID_W];

  // Heap memory with two registered read ports; the map follows each write.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
      map_mem[wr_owner[MAP_AW-1:0]] <= heap_wa;
    end
    if (rd_a_en) rd_a_r <= heap_mem[rd_a_addr];
    if (rd_b_en) rd_b_r <= heap_mem[rd_b_addr];
    if (op == tmh_pkg::OP_MAP_RD) slot_rd_r <= map_mem[id_r[MAP_AW-1:0]];
  end

  // Control state: heap count, pending tick result and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (op)
        tmh_pkg::OP_LOAD:      pend_r <= 1'b0;
        tmh_pkg::OP_CLEAR:     cnt_r  <= '0;
        tmh_pkg::OP_START_NEW: cnt_r  <= cnt_r + CNT_W'(1);
        tmh_pkg::OP_LAST_RD:   cnt_r  <= cnt_r - CNT_W'(1);
        tmh_pkg::OP_TICK_POP:  pend_r <= 1'b1;
        default: ;
      endcase
      // A result is raised by an emit or by a pop that releases the previous timer.
      if ((op == tmh_pkg::OP_EMIT) || ((op == tmh_pkg::OP_TICK_POP) && pend_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      tmh_pkg::OP_LOAD: begin
        act_r        <= in_action;
        id_r         <= in_timer_id;
        exp_r        <= in_expire_time[KEY_W-1:0];
        now_r        <= in_now_time[KEY_W-1:0];
        res_fired_r  <= 1'b0;
        res_id_r     <= '0;
        res_status_r <= tmh_pkg::ST_OK;
      end
      tmh_pkg::OP_SET_UNKNOWN: res_status_r <= tmh_pkg::ST_UNKNOWN;
      tmh_pkg::OP_SET_FULL:    res_status_r <= tmh_pkg::ST_FULL;
      tmh_pkg::OP_START_KNOWN: begin
        ent_r   <= {id_r, exp_r};
        hole_r  <= slot_rd_r;
        lim_r   <= cnt_r;
        moved_r <= 1'b0;
      end
      tmh_pkg::OP_START_NEW: begin
        ent_r   <= {id_r, exp_r};
        hole_r  <= cnt_r[IDX_W-1:0];
        lim_r   <= cnt_r + CNT_W'(1);
        moved_r <= 1'b0;
      end
      tmh_pkg::OP_START_FIRE: begin
        res_fired_r <= 1'b1;
        res_id_r    <= id_r;
        hole_r      <= slot_rd_r;
      end
      tmh_pkg::OP_TAKE_LAST: begin
        ent_r   <= rd_a_r;
        lim_r   <= cnt_r;
        moved_r <= 1'b0;
      end
      tmh_pkg::OP_MOVE_DOWN: begin
        hole_r  <= pick_idx;
        moved_r <= 1'b1;
      end
      tmh_pkg::OP_MOVE_UP: hole_r <= parent;
      tmh_pkg::OP_TICK_POP: begin
        pend_id_r <= rd_a_r[ENT_W-1 -: ID_W];
        hole_r    <= '0;
        // The previous expired timer is now known not to be the final one.
        if (pend_r) begin
          out_fired_r  <= 1'b1;
          out_id_r     <= pend_id_r;
          out_last_r   <= 1'b0;
          out_status_r <= tmh_pkg::ST_OK;
        end
      end
      tmh_pkg::OP_TICK_END: begin
        res_fired_r <= pend_r;
        res_id_r    <= pend_r ? pend_id_r : '0;
      end
      tmh_pkg::OP_EMIT: begin
        out_fired_r  <= res_fired_r;
        out_id_r     <= res_id_r;
        out_last_r   <= 1'b1;
        out_status_r <= res_status_r;
      end
      default: ;
    endcase
  end

  // Status towards the controller.
  always_comb begin
    status.act       = act_r;
    status.id_ok     = 32'(id_r) < ID_COUNT;
    status.known     = status.id_ok && (CNT_W'(slot_rd_r) < cnt_r) &&
                       (rd_a_r[ENT_W-1 -: ID_W] == id_r);
    status.full      = cnt_r >= CNT_W'(HEAP_DEPTH);
    status.cnt_zero  = cnt_r == '0;
    status.has_child = child_l < J_W'(lim_r);
    status.dn_stop   = ent_r[KEY_W-1:0] < pick_ent[KEY_W-1:0];
    status.moved     = moved_r;
    status.hole_root = hole_r == '0;
    status.up_stop   = rd_a_r[KEY_W-1:0] < ent_r[KEY_W-1:0];
    status.rm_move   = CNT_W'(hole_r) < cnt_r;
    status.due       = rd_a_r[KEY_W-1:0] <= now_r;
    status.pend      = pend_r;
    status.out_free  = out_free;
  end

  assign out_valid    = out_valid_r;
  assign out_fired    = out_fired_r;
  assign out_fired_id = out_id_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

### hdl/timer_min_heap.sv
// Timer queue kept as a binary min-heap on expiry time, with an id-to-slot map.
// One action is taken at a time. An add or modify reads the map entry and the
// slot, then moves the entry through the heap one level at a time; a fire-now
// removes the timer by moving the last entry into its slot; a tick does one
// such removal per expired timer and gives one result per expired timer, or a
// single result when none is due. Each level takes a read state and a compare
// state, because the heap memory has registered read ports. A result that
// waits on the output holds the block until it is taken.
// No clearing pass is needed after reset: a map entry counts only if it points
// below the heap count at a slot that names the same id.
// Depends on tmh_pkg, tmh_in_if, tmh_out_if, tmh_ctrl and tmh_dpath.
`default_nettype none

module timer_min_heap #(
  parameter int HEAP_DEPTH = 64,
  parameter int ID_COUNT   = 256,
  parameter int TIME_BITS  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tmh_in_if.sink     in_ch,
  tmh_out_if.source  out_ch
);

  tmh_pkg::dp_op_t     op;
  tmh_pkg::dp_status_t status;

  // Sequencer.
  tmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .op        (op)
  );

  // Storage and compare logic.
  tmh_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .ID_COUNT   (ID_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .status         (status),
    .in_action      (in_ch.action),
    .in_timer_id    (in_ch.timer_id),
    .in_expire_time (in_ch.expire_time),
    .in_now_time    (in_ch.now_time),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_fired      (out_ch.fired),
    .out_fired_id   (out_ch.fired_id),
    .out_last       (out_ch.last),
    .out_status     (out_ch.status)
  );

endmodule

`default_nettype wire

### hdl/tmh_checker.sv
// Port-level checks for the timer min-heap, attached by bind to the top level.
// Depends on tmh_pkg for field widths and status codes.
`default_nettype none

module tmh_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_fired,
  input wire logic [tmh_pkg::ID_W-1:0]     out_fired_id,
  input wire logic                         out_last,
  input wire logic [tmh_pkg::STATUS_W-1:0] out_status
);

  // A result that waits stays valid and keeps its id and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_id) && $stable(out_last))
    else $error("result changed while stalled");

  // No new action is taken while a burst of expired timers is still going out.
  a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready during a tick burst");

  // After a transfer in, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second action taken back to back");

  // A result that reports no timer carries a zero id.
  a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_fired_id == '0)
    else $error("non-zero id on a result without a fired timer");

  // An error status ends the action and never names a timer.
  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != tmh_pkg::ST_OK) |-> out_last && !out_fired)
    else $error("error status on a fired or non-final result");

endmodule

bind timer_min_heap tmh_checker u_tmh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_fired    (out_ch.fired),
  .out_fired_id (out_ch.fired_id),
  .out_last     (out_ch.last),
  .out_status   (out_ch.status)
);

`default_nettype wire

### tb/tmh_scoreboard.sv
// Scoreboard for the timer min-heap: a heap predictor and a queue of expected results.
// Depends on tmh_pkg for the action and status codes.
`timescale 1ns / 1ps

class tmh_scoreboard;
  localparam int DEPTH = 64;
  localparam int IDS   = 256;

  typedef struct {
    logic       fired;
    logic [7:0] fired_id;
    logic       last;
    logic [1:0] status;
  } timer_result_t;

  logic [31:0]   slot_expiry [DEPTH];
  logic [7:0]    slot_owner  [DEPTH];
  int unsigned   id_slot     [IDS];
  bit            id_live     [IDS];
  int unsigned   live_count;
  timer_result_t pending_results [$];
  int            error_count;

  function new();
    live_count  = 0;
    error_count = 0;
    foreach (id_live[i]) id_live[i] = 0;
  endfunction

  function void exchange(int unsigned a, int unsigned b);
    logic [31:0] e;
    logic [7:0]  o;
    e = slot_expiry[a]; o = slot_owner[a];
    slot_expiry[a] = slot_expiry[b]; slot_owner[a] = slot_owner[b];
    slot_expiry[b] = e; slot_owner[b] = o;
    id_slot[slot_owner[a]] = a;
    id_slot[slot_owner[b]] = b;
  endfunction

  function void bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (slot_expiry[p] < slot_expiry[i]) break;
      exchange(i, p);
      i = p;
    end
  endfunction

  function bit bubble_down(int unsigned start, int unsigned n);
    int unsigned i, j;
    i = start;
    j = 2 * i + 1;
    while (j < n) begin
      if (j + 1 < n && slot_expiry[j+1] < slot_expiry[j]) j++;
      if (slot_expiry[i] < slot_expiry[j]) break;
      exchange(i, j);
      i = j;
      j = 2 * i + 1;
    end
    return i > start;
  endfunction

  function void drop_slot(int unsigned i);
    int unsigned n;
    n = live_count - 1;
    if (i < n) begin
      exchange(i, n);
      if (!bubble_down(i, n)) bubble_up(i);
    end
    id_live[slot_owner[n]] = 0;
    live_count = n;
  endfunction

  function void push(logic f, logic [7:0] id, logic l, logic [1:0] st);
    timer_result_t r;
    r.fired = f; r.fired_id = id; r.last = l; r.status = st;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Predict the results of one accepted input transfer.
  function void note_input(logic [2:0] act, logic [7:0] id, logic [31:0] expiry,
                           logic [31:0] now);
    int unsigned s;
    int k;
    case (act)
      tmh_pkg::ACT_ADD: begin
        if (id_live[id]) begin
          s = id_slot[id];
          slot_expiry[s] = expiry;
          if (!bubble_down(s, live_count)) bubble_up(s);
          push(0, 0, 1, tmh_pkg::ST_OK);
        end else if (live_count >= DEPTH) begin
          push(0, 0, 1, tmh_pkg::ST_FULL);
        end else begin
          s = live_count;
          slot_expiry[s] = expiry;
          slot_owner[s] = id;
          id_slot[id] = s;
          id_live[id] = 1;
          live_count = s + 1;
          bubble_up(s);
          push(0, 0, 1, tmh_pkg::ST_OK);
        end
      end
      tmh_pkg::ACT_MODIFY: begin
        if (!id_live[id]) begin
          push(0, 0, 1, tmh_pkg::ST_UNKNOWN);
        end else begin
          s = id_slot[id];
          slot_expiry[s] = expiry;
          if (!bubble_down(s, live_count)) bubble_up(s);
          push(0, 0, 1, tmh_pkg::ST_OK);
        end
      end
      tmh_pkg::ACT_TICK: begin
        k = 0;
        while (live_count > 0 && slot_expiry[0] <= now) begin
          push(1, slot_owner[0], 0, tmh_pkg::ST_OK);
          k++;
          drop_slot(0);
        end
        if (k == 0) push(0, 0, 1, tmh_pkg::ST_OK);
        else pending_results[$].last = 1;
      end
      tmh_pkg::ACT_FIRE: begin
        if (!id_live[id]) begin
          push(0, 0, 1, tmh_pkg::ST_UNKNOWN);
        end else begin
          push(1, id, 1, tmh_pkg::ST_OK);
          drop_slot(id_slot[id]);
        end
      end
      tmh_pkg::ACT_CLEAR: begin
        foreach (id_live[i]) id_live[i] = 0;
        live_count = 0;
        push(0, 0, 1, tmh_pkg::ST_OK);
      end
      default: push(0, 0, 1, tmh_pkg::ST_OK);
    endcase
  endfunction

  // Compare one result transfer with the oldest expectation.
  function void check_result(logic f, logic [7:0] id, logic l, logic [1:0] st);
    timer_result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result fired=%0d id=%0d last=%0d status=%0d",
               $time, f, id, l, st);
      error_count++;
      return;
    end
    e = pending_results.pop_front();
    if (f !== e.fired || id !== e.fired_id || l !== e.last || st !== e.status) begin
      $display("%0t: mismatch expected fired=%0d id=%0d last=%0d status=%0d, actual fired=%0d id=%0d last=%0d status=%0d",
               $time, e.fired, e.fired_id, e.last, e.status, f, id, l, st);
      error_count++;
    end
  endfunction
endclass

### tb/tb_timer_min_heap.sv
// Testbench top for the timer min-heap: directed and random actions, random idling.
// Depends on tmh_pkg, tmh_in_if, tmh_out_if, tmh_scoreboard and timer_min_heap.
`timescale 1ns / 1ps

module tb_timer_min_heap;

  logic clk;
  logic rst_n;
  bit   sending_done;

  tmh_in_if  in_ch ();
  tmh_out_if out_ch ();

  tmh_scoreboard timer_board;

  timer_min_heap u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Clock with a 10 ns period.
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Send one action and wait for its transfer; valid stays high until the next
  // action or an idle gap, while the block is busy.
  task automatic send_action(logic [2:0] act, logic [7:0] id, logic [31:0] expiry,
                             logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1;
    in_ch.action      <= act;
    in_ch.timer_id    <= id;
    in_ch.expire_time <= expiry;
    in_ch.now_time    <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    timer_board.note_input(act, id, expiry, now);
  endtask

  // Drop valid and pause until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (timer_board.pending_results.size() != 0) @(negedge clk);
  endtask

  // Random expiry, mostly from a small window so ticks catch a few timers.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  // Result side: random stalls, sampled at the rising edge.
  initial begin
    int stall;
    out_ch.ready = 0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      timer_board.check_result(out_ch.fired, out_ch.fired_id, out_ch.last, out_ch.status);
    end
  end

  // Stimulus.
  initial begin
    logic [7:0] id;
    timer_board = new();
    in_ch.valid = 0;
    in_ch.action = tmh_pkg::ACT_ADD;
    in_ch.timer_id = 0;
    in_ch.expire_time = 0;
    in_ch.now_time = 0;
    rst_n = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1;

    // Directed: every action, field extremes, the special cases.
    send_action(tmh_pkg::ACT_TICK, 0, 0, 32'hFFFF_FFFF);
    send_action(tmh_pkg::ACT_MODIFY, 8'd5, 10, 0);
    send_action(tmh_pkg::ACT_FIRE, 8'd255, 0, 0);
    send_action(tmh_pkg::ACT_ADD, 8'd0, 32'hFFFF_FFFF, 0);
    send_action(tmh_pkg::ACT_ADD, 8'd255, 0, 0);
    send_action(tmh_pkg::ACT_ADD, 8'd7, 100, 0);
    send_action(tmh_pkg::ACT_ADD, 8'd7, 50, 0);
    send_action(tmh_pkg::ACT_MODIFY, 8'd255, 200, 0);
    send_action(tmh_pkg::ACT_ADD, 8'd9, 50, 0);
    send_action(3'd5, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_action(3'd7, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555);
    send_action(tmh_pkg::ACT_TICK, 0, 0, 49);
    send_action(tmh_pkg::ACT_TICK, 0, 0, 100);
    send_action(tmh_pkg::ACT_FIRE, 8'd0, 0, 0);
    send_action(tmh_pkg::ACT_TICK, 0, 0, 32'hFFFF_FFFF);
    // Fill the heap, then try one more new id.
    for (int i = 0; i < 64; i++) begin
      send_action(tmh_pkg::ACT_ADD, i[7:0], $urandom_range(0, 1000), 0);
    end
    send_action(tmh_pkg::ACT_ADD, 8'd200, 5, 0);
    send_action(tmh_pkg::ACT_ADD, 8'd3, 2000, 0);
    drain();
    send_action(tmh_pkg::ACT_TICK, 0, 0, 32'hFFFF_FFFF);
    send_action(tmh_pkg::ACT_ADD, 8'd1, 1, 0);
    send_action(tmh_pkg::ACT_CLEAR, 0, 0, 0);
    send_action(tmh_pkg::ACT_FIRE, 8'd1, 0, 0);

    // Random: mostly adds and updates on a small id pool, with ticks and removals.
    for (int n = 0; n < 45; n++) begin
      id = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 31));
      case ($urandom_range(0, 19))
        0,1,2,3,4,5,6,7: send_action(tmh_pkg::ACT_ADD, id, pick_time(), $urandom());
        8,9,10:          send_action(tmh_pkg::ACT_MODIFY, id, pick_time(), $urandom());
        11,12,13:        send_action(tmh_pkg::ACT_TICK, id, $urandom(), pick_time());
        14,15,16:        send_action(tmh_pkg::ACT_FIRE, id, $urandom(), $urandom());
        17:              send_action(tmh_pkg::ACT_CLEAR, id, $urandom(), $urandom());
        default:         send_action(3'($urandom_range(5, 7)), id, $urandom(), $urandom());
      endcase
      if (n == 20) drain();
    end
    sending_done = 1;
  end

  // End of run.
  initial begin
    wait (sending_done);
    drain();
    repeat (200) @(negedge clk);
    if (timer_board.error_count == 0 && timer_board.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
